### design/sidcs_pkg.sv
package sidcs_pkg;

   localparam int ID_BITS_DEFAULT    = 32;
   localparam int INDEX_BITS_DEFAULT = 24;

   localparam int DIM_BITS    = 16;
   localparam int OFFSET_BITS = 24;
   localparam int LENGTH_BITS = 25;
   localparam int NUMBER_BITS = 24;

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DIM_LENGTH = '0;
   localparam logic [DIM_BITS-1:0]       DIM_LENGTH_RESET = 16'd1;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] column_offset;
      logic [LENGTH_BITS-1:0] column_length;
      logic [NUMBER_BITS-1:0] column_number;
      logic                   ends_set;
      logic [LENGTH_BITS-1:0] set_column_count;
      logic                   last_result;
   } result_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic {
      SEG_CHECK,
      SEG_FINAL
   } seg_state_type;

endpackage

### design/sidcs_divider.sv
module sidcs_divider #(
   parameter int ID_BITS = sidcs_pkg::ID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_push,
   output logic                          in_ready,
   input  logic [ID_BITS-1:0]            in_id,
   input  logic                          in_last,
   input  logic [sidcs_pkg::DIM_BITS-1:0] divisor,
   output logic                          out_push,
   input  logic                          out_full,
   output logic [ID_BITS-1:0]            out_column,
   output logic [sidcs_pkg::DIM_BITS-1:0] out_position,
   output logic                          out_last
);
   import sidcs_pkg::*;

   localparam int CNT_BITS = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;

   div_state_type         state_ff, state_in;
   logic [ID_BITS-1:0]    quo_ff, quo_in;
   logic [DIM_BITS-1:0]   rem_ff, rem_in;
   logic [DIM_BITS-1:0]   div_ff, div_in;
   logic                  last_ff, last_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIM_BITS:0]     shifted;
   logic [DIM_BITS:0]     diff;
   logic                  ge;
   logic                  accept;

   assign accept  = in_push && (state_ff == DIV_IDLE);
   assign shifted = {rem_ff, quo_ff[ID_BITS-1]};
   assign ge      = shifted >= {1'b0, div_ff};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (in_push) begin
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (!out_full) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      in_ready = (state_ff == DIV_IDLE);
      out_push = (state_ff == DIV_DONE);
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         quo_in  = in_id;
         rem_in  = '0;
         div_in  = (divisor == '0) ? DIM_BITS'(1) : divisor;
         last_in = in_last;
         cnt_in  = CNT_BITS'(ID_BITS - 1);
      end else if (state_ff == DIV_RUN) begin
         quo_in = {quo_ff[ID_BITS-2:0], ge};
         rem_in = ge ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      last_ff <= last_in;
      cnt_ff  <= cnt_in;
   end

   assign out_column   = quo_ff;
   assign out_position = rem_ff;
   assign out_last     = last_ff;

endmodule

### design/sidcs_queue.sv
module sidcs_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import sidcs_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### design/sidcs_segmenter.sv
module sidcs_segmenter #(
   parameter int ID_BITS    = sidcs_pkg::ID_BITS_DEFAULT,
   parameter int INDEX_BITS = sidcs_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_empty,
   output logic                           in_pop,
   input  logic [ID_BITS-1:0]             in_column,
   input  logic [sidcs_pkg::DIM_BITS-1:0] in_position,
   input  logic                           in_last,
   output logic                           out_empty,
   input  logic                           out_pop,
   output sidcs_pkg::result_type          out_result
);
   import sidcs_pkg::*;

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   seg_state_type          state_ff, state_in;
   logic [ID_BITS-1:0]     prev_col_ff, prev_col_in;
   logic [DIM_BITS-1:0]    prev_pos_ff, prev_pos_in;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [INDEX_BITS-1:0]  start_ff, start_in;
   logic [INDEX_BITS-1:0]  count_ff, count_in;
   logic [INDEX_BITS-1:0]  set_first_ff, set_first_in;
   result_type             out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic                   can_load;
   logic                   go;
   logic                   set_end;
   logic                   brk;
   logic                   emit_break;
   logic                   emit_final;
   logic [INDEX_BITS-1:0]  count_sat;
   logic [INDEX_BITS-1:0]  idx_sat;
   logic [INDEX_BITS:0]    brk_len;
   logic [INDEX_BITS:0]    fin_len;
   logic [INDEX_BITS:0]    set_cnt;

   assign can_load   = !out_valid_ff || out_pop;
   assign go         = !in_empty && can_load;
   assign set_end    = (in_column != prev_col_ff);
   assign brk        = (state_ff == SEG_CHECK) && (idx_ff != '0)
                    && (set_end || ({1'b0, in_position} != {1'b0, prev_pos_ff} + 17'd1));
   assign emit_break = go && brk;
   assign emit_final = in_pop && in_last;
   assign count_sat  = (count_ff == INDEX_MAX) ? INDEX_MAX : count_ff + INDEX_BITS'(1);
   assign idx_sat    = (idx_ff == INDEX_MAX) ? INDEX_MAX : idx_ff + INDEX_BITS'(1);
   assign brk_len    = {1'b0, idx_ff} - {1'b0, start_ff};
   assign fin_len    = {1'b0, idx_ff} + (INDEX_BITS+1)'(1) - {1'b0, start_ff};
   assign set_cnt    = {1'b0, count_ff} - {1'b0, set_first_ff} + (INDEX_BITS+1)'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEG_CHECK: begin
            if (emit_break && in_last) begin
               state_in = SEG_FINAL;
            end
         end
         SEG_FINAL: begin
            if (go) begin
               state_in = SEG_CHECK;
            end
         end
         default: state_in = SEG_CHECK;
      endcase
   end

   always_comb begin
      in_pop    = go && !(brk && in_last);
      out_empty = !out_valid_ff;
   end

   always_comb begin
      prev_col_in  = prev_col_ff;
      prev_pos_in  = prev_pos_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      set_first_in = set_first_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_pop;

      if (emit_break) begin
         out_in.column_offset    = OFFSET_BITS'(start_ff);
         out_in.column_length    = LENGTH_BITS'(brk_len);
         out_in.column_number    = NUMBER_BITS'(count_ff);
         out_in.ends_set         = set_end;
         out_in.set_column_count = set_end ? LENGTH_BITS'(set_cnt) : '0;
         out_in.last_result      = 1'b0;
         out_valid_in            = 1'b1;
         count_in                = count_sat;
         start_in                = idx_ff;
         if (set_end) begin
            set_first_in = count_sat;
         end
      end else if (emit_final) begin
         out_in.column_offset    = OFFSET_BITS'(start_ff);
         out_in.column_length    = LENGTH_BITS'(fin_len);
         out_in.column_number    = NUMBER_BITS'(count_ff);
         out_in.ends_set         = 1'b1;
         out_in.set_column_count = LENGTH_BITS'(set_cnt);
         out_in.last_result      = 1'b1;
         out_valid_in            = 1'b1;
      end

      if (in_pop) begin
         if (in_last) begin
            prev_col_in  = '0;
            prev_pos_in  = '0;
            idx_in       = '0;
            start_in     = '0;
            count_in     = '0;
            set_first_in = '0;
         end else begin
            prev_col_in = in_column;
            prev_pos_in = in_position;
            idx_in      = idx_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEG_CHECK;
         prev_col_ff  <= '0;
         prev_pos_ff  <= '0;
         idx_ff       <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         set_first_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_col_ff  <= prev_col_in;
         prev_pos_ff  <= prev_pos_in;
         idx_ff       <= idx_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         set_first_ff <= set_first_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign out_result = out_ff;

endmodule

### design/sorted_id_column_segmenter_unit.sv
// Sorted ID column segmenter.
// Input queue side: present req_mapped_id and req_last_item with push; a transfer
// happens on a clock edge with push high and full low. IDs arrive in ascending
// order; req_last_item closes the sequence and the block then starts a new one.
// Result queue side: while empty is low the oldest column record sits on the
// rsp_ ports; pop with empty low takes it. One item gives zero, one or two records.
// Each item passes through the front divider, which restores one quotient bit per
// cycle; the divider takes no new item until it has handed the last one on, and
// full stays high meanwhile. A record reaches the result ports through the queue
// and the tracker's output register; a second record of the same item follows in
// the cycle after the first at the earliest. A two-entry queue sits between the
// divider and the column tracker, and a one-entry output register holds the
// record; if the receiver stalls, the tracker waits, the queue fills, full rises.
// Synchronous active-high reset empties both queues, clears the sequence state
// and sets dim_length to 1. Write dim_length over the APB port (byte address 0)
// only while no item is in flight; a value of 0 acts as 1.
module sorted_id_column_segmenter_unit #(
   parameter int ID_BITS    = sidcs_pkg::ID_BITS_DEFAULT,
   parameter int INDEX_BITS = sidcs_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [ID_BITS-1:0]                  req_mapped_id,
   input  logic                                req_last_item,
   output logic                                empty,
   input  logic                                pop,
   output logic [sidcs_pkg::OFFSET_BITS-1:0]   rsp_column_offset,
   output logic [sidcs_pkg::LENGTH_BITS-1:0]   rsp_column_length,
   output logic [sidcs_pkg::NUMBER_BITS-1:0]   rsp_column_number,
   output logic                                rsp_ends_set,
   output logic [sidcs_pkg::LENGTH_BITS-1:0]   rsp_set_column_count,
   output logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sidcs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [sidcs_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [sidcs_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);
   import sidcs_pkg::*;

   localparam int QW = ID_BITS + DIM_BITS + 1;

   logic [DIM_BITS-1:0]       dim_length_ff, dim_length_in;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic                      csr_write;

   logic                      div_ready;
   logic                      div_push;
   logic [ID_BITS-1:0]        div_column;
   logic [DIM_BITS-1:0]       div_position;
   logic                      div_last;
   logic                      q_full;
   logic                      q_empty;
   logic                      q_pop;
   logic [QW-1:0]             q_rd_data;
   result_type                result;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (csr_index == REG_DIM_LENGTH) ? CSR_DATA_BITS'(dim_length_ff) : '0;

   always_comb begin
      dim_length_in = dim_length_ff;
      if (csr_write && (csr_index == REG_DIM_LENGTH)) begin
         dim_length_in = pwdata[DIM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_length_ff <= DIM_LENGTH_RESET;
      end else begin
         dim_length_ff <= dim_length_in;
      end
   end

   assign full = !div_ready;

   sidcs_divider #(
      .ID_BITS (ID_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_push      (push),
      .in_ready     (div_ready),
      .in_id        (req_mapped_id),
      .in_last      (req_last_item),
      .divisor      (dim_length_ff),
      .out_push     (div_push),
      .out_full     (q_full),
      .out_column   (div_column),
      .out_position (div_position),
      .out_last     (div_last)
   );

   sidcs_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (div_push),
      .wr_data ({div_column, div_position, div_last}),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   sidcs_segmenter #(
      .ID_BITS    (ID_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_segmenter (
      .clock       (clock),
      .reset       (reset),
      .in_empty    (q_empty),
      .in_pop      (q_pop),
      .in_column   (q_rd_data[QW-1 -: ID_BITS]),
      .in_position (q_rd_data[DIM_BITS:1]),
      .in_last     (q_rd_data[0]),
      .out_empty   (empty),
      .out_pop     (pop),
      .out_result  (result)
   );

   assign rsp_column_offset    = result.column_offset;
   assign rsp_column_length    = result.column_length;
   assign rsp_column_number    = result.column_number;
   assign rsp_ends_set         = result.ends_set;
   assign rsp_set_column_count = result.set_column_count;
   assign rsp_last_result      = result.last_result;

endmodule

### design/sidcs_checker.sv
module sidcs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                empty,
   input logic                                pop,
   input logic [sidcs_pkg::LENGTH_BITS-1:0]   rsp_column_length,
   input logic                                rsp_ends_set,
   input logic [sidcs_pkg::LENGTH_BITS-1:0]   rsp_set_column_count,
   input logic                                rsp_last_result
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_column_length)))
      else $error("stalled result transfer dropped");

   a_count_only_on_set_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_ends_set) |-> (rsp_set_column_count == '0))
      else $error("set column count without set end");

   a_last_closes_set: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_result) |-> (rsp_ends_set && rsp_set_column_count != '0))
      else $error("final column does not close its set");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_ends_set) |-> (rsp_set_column_count != '0))
      else $error("closed set with zero columns");

endmodule

bind sorted_id_column_segmenter_unit sidcs_checker u_sidcs_checker (
   .clock                (clock),
   .reset                (reset),
   .empty                (empty),
   .pop                  (pop),
   .rsp_column_length    (rsp_column_length),
   .rsp_ends_set         (rsp_ends_set),
   .rsp_set_column_count (rsp_set_column_count),
   .rsp_last_result      (rsp_last_result)
);

### bench/sidcs_column_checker.sv
module sidcs_column_checker #(
   parameter int ID_BITS    = sidcs_pkg::ID_BITS_DEFAULT,
   parameter int INDEX_BITS = sidcs_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic [ID_BITS-1:0]                  req_mapped_id,
   input  logic                                req_last_item,
   input  logic                                empty,
   input  logic                                pop,
   input  logic [sidcs_pkg::OFFSET_BITS-1:0]   rsp_column_offset,
   input  logic [sidcs_pkg::LENGTH_BITS-1:0]   rsp_column_length,
   input  logic [sidcs_pkg::NUMBER_BITS-1:0]   rsp_column_number,
   input  logic                                rsp_ends_set,
   input  logic [sidcs_pkg::LENGTH_BITS-1:0]   rsp_set_column_count,
   input  logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sidcs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [sidcs_pkg::CSR_DATA_BITS-1:0] pwdata,
   input  logic [sidcs_pkg::CSR_DATA_BITS-1:0] prdata,
   input  logic                                pready,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  ids_seen,
   output int                                  records_seen,
   output int                                  sets_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   import sidcs_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [DIM_BITS-1:0]   dim_length;
   logic [ID_BITS-1:0]    prev_col;
   logic [DIM_BITS-1:0]   prev_pos;
   logic [INDEX_BITS-1:0] item_idx;
   logic [INDEX_BITS-1:0] col_start;
   logic [INDEX_BITS-1:0] col_cnt;
   logic [INDEX_BITS-1:0] set_first;

   result_type expected_columns[$];
   result_type seen_rec;
   result_type want_rec;

   function automatic logic [INDEX_BITS-1:0] bump(input logic [INDEX_BITS-1:0] v);
      return (v == '1) ? v : v + INDEX_BITS'(1);
   endfunction

   function automatic result_type column_record(input logic [LENGTH_BITS-1:0] length,
                                                input logic set_end, input logic fin);
      result_type rec;
      rec.column_offset    = OFFSET_BITS'(col_start);
      rec.column_length    = length;
      rec.column_number    = NUMBER_BITS'(col_cnt);
      rec.ends_set         = set_end;
      rec.set_column_count = set_end ?
                             LENGTH_BITS'(col_cnt) - LENGTH_BITS'(set_first)
                             + LENGTH_BITS'(1) : '0;
      rec.last_result      = fin;
      return rec;
   endfunction

   task automatic clear_sequence();
      prev_col  = '0;
      prev_pos  = '0;
      item_idx  = '0;
      col_start = '0;
      col_cnt   = '0;
      set_first = '0;
   endtask

   task automatic track_item(input logic [ID_BITS-1:0] id, input logic fin);
      logic [ID_BITS-1:0]  divisor;
      logic [ID_BITS-1:0]  col;
      logic [DIM_BITS-1:0] pos;
      logic                split;
      logic                new_set;
      divisor = (dim_length == '0) ? ID_BITS'(1) : ID_BITS'(dim_length);
      col     = id / divisor;
      pos     = DIM_BITS'(id % divisor);
      split   = (item_idx != '0) &&
                (col != prev_col ||
                 {1'b0, pos} != {1'b0, prev_pos} + (DIM_BITS+1)'(1));
      if (split) begin
         new_set = (col != prev_col);
         expected_columns = {expected_columns, column_record(
            LENGTH_BITS'(item_idx) - LENGTH_BITS'(col_start), new_set, 1'b0)};
         col_cnt   = bump(col_cnt);
         col_start = item_idx;
         if (new_set) begin
            set_first = col_cnt;
         end
      end
      if (fin) begin
         expected_columns = {expected_columns, column_record(
            LENGTH_BITS'(item_idx) + LENGTH_BITS'(1) - LENGTH_BITS'(col_start),
            1'b1, 1'b1)};
         clear_sequence();
      end else begin
         prev_col = col;
         prev_pos = pos;
         item_idx = bump(item_idx);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dim_length = DIM_LENGTH_RESET;
         clear_sequence();
         expected_columns.delete();
         mismatches   = 0;
         ids_seen     = 0;
         records_seen = 0;
         sets_closed  = 0;
      end else begin
         if (pop && !empty) begin
            seen_rec.column_offset    = rsp_column_offset;
            seen_rec.column_length    = rsp_column_length;
            seen_rec.column_number    = rsp_column_number;
            seen_rec.ends_set         = rsp_ends_set;
            seen_rec.set_column_count = rsp_set_column_count;
            seen_rec.last_result      = rsp_last_result;
            records_seen++;
            if (expected_columns.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: unexpected column record off=%0d len=%0d num=%0d",
                           $realtime, rsp_column_offset, rsp_column_length,
                           rsp_column_number);
               end
            end else begin
               want_rec = expected_columns.pop_front();
               if (want_rec.ends_set) begin
                  sets_closed++;
               end
               if (seen_rec.column_offset    !== want_rec.column_offset    ||
                   seen_rec.column_length    !== want_rec.column_length    ||
                   seen_rec.column_number    !== want_rec.column_number    ||
                   seen_rec.ends_set         !== want_rec.ends_set         ||
                   seen_rec.set_column_count !== want_rec.set_column_count ||
                   seen_rec.last_result      !== want_rec.last_result) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: column record mismatch", $realtime);
                     $display("   expected off=%0d len=%0d num=%0d set=%0b cnt=%0d last=%0b",
                              want_rec.column_offset, want_rec.column_length,
                              want_rec.column_number, want_rec.ends_set,
                              want_rec.set_column_count, want_rec.last_result);
                     $display("   actual   off=%0d len=%0d num=%0d set=%0b cnt=%0d last=%0b",
                              seen_rec.column_offset, seen_rec.column_length,
                              seen_rec.column_number, seen_rec.ends_set,
                              seen_rec.set_column_count, seen_rec.last_result);
                  end
               end
            end
         end
         if (psel && penable && pready && paddr[1:0] == 2'b00 &&
             paddr[CSR_ADDR_BITS-1:2] == REG_DIM_LENGTH) begin
            if (pwrite) begin
               dim_length = pwdata[DIM_BITS-1:0];
            end else if (prdata !== CSR_DATA_BITS'(dim_length)) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: dim_length read mismatch expected %0d actual %0d",
                           $realtime, dim_length, prdata);
               end
            end
         end
         if (push && !full) begin
            ids_seen++;
            track_item(req_mapped_id, req_last_item);
         end
      end
      outstanding = expected_columns.size();
   end

endmodule

### bench/sorted_id_column_segmenter_unit_tb.sv
module sorted_id_column_segmenter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sidcs_pkg::*;

   localparam int ID_BITS       = ID_BITS_DEFAULT;
   localparam int INDEX_BITS    = INDEX_BITS_DEFAULT;
   localparam int SETTLE_CYCLES = 4 * (ID_BITS + 4);
   localparam int PHASE_IDS     = 65;
   localparam logic [CSR_ADDR_BITS-1:0] DIM_LENGTH_ADDR = {REG_DIM_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] UNMAPPED_ADDR   = {~REG_DIM_LENGTH, 2'b00};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic [ID_BITS-1:0]        req_mapped_id = '0;
   logic                      req_last_item = 1'b0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [OFFSET_BITS-1:0]    rsp_column_offset;
   logic [LENGTH_BITS-1:0]    rsp_column_length;
   logic [NUMBER_BITS-1:0]    rsp_column_number;
   logic                      rsp_ends_set;
   logic [LENGTH_BITS-1:0]    rsp_set_column_count;
   logic                      rsp_last_result;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  paddr = '0;
   logic [CSR_DATA_BITS-1:0]  pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   int mismatches;
   int outstanding;
   int ids_seen;
   int records_seen;
   int sets_closed;

   int burst_left = 1;
   int divisor_settings = 1;
   int pop_mode = 0;
   int pop_mode_left = 0;
   logic [DIM_BITS-1:0] dim_now = DIM_LENGTH_RESET;

   always #2 clock = ~clock;

   sorted_id_column_segmenter_unit #(
      .ID_BITS   (ID_BITS),
      .INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_mapped_id       (req_mapped_id),
      .req_last_item       (req_last_item),
      .empty               (empty),
      .pop                 (pop),
      .rsp_column_offset   (rsp_column_offset),
      .rsp_column_length   (rsp_column_length),
      .rsp_column_number   (rsp_column_number),
      .rsp_ends_set        (rsp_ends_set),
      .rsp_set_column_count(rsp_set_column_count),
      .rsp_last_result     (rsp_last_result),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   sidcs_column_checker #(
      .ID_BITS   (ID_BITS),
      .INDEX_BITS(INDEX_BITS)
   ) records (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_mapped_id       (req_mapped_id),
      .req_last_item       (req_last_item),
      .empty               (empty),
      .pop                 (pop),
      .rsp_column_offset   (rsp_column_offset),
      .rsp_column_length   (rsp_column_length),
      .rsp_column_number   (rsp_column_number),
      .rsp_ends_set        (rsp_ends_set),
      .rsp_set_column_count(rsp_set_column_count),
      .rsp_last_result     (rsp_last_result),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready),
      .mismatches          (mismatches),
      .outstanding         (outstanding),
      .ids_seen            (ids_seen),
      .records_seen        (records_seen),
      .sets_closed         (sets_closed)
   );

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop_mode_left == 0) begin
            pop_mode      = $urandom_range(0, 2);
            pop_mode_left = $urandom_range(20, 80);
         end
         pop_mode_left--;
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            default: pop <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == DIM_LENGTH_ADDR) begin
         dim_now = data[DIM_BITS-1:0];
         divisor_settings++;
      end
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_BITS-1:0] addr);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_id(input logic [ID_BITS-1:0] id, input logic fin);
      int gap;
      req_mapped_id <= id;
      req_last_item <= fin;
      push          <= 1'b1;
      do @(posedge clock); while (full);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic hold_for_columns();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic drain_block();
      hold_for_columns();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int id_budget);
      longint cur;
      longint eff;
      int     sent;
      int     len;
      int     k;
      int     pick;
      logic   fin;
      sent = 0;
      eff  = (dim_now == '0) ? 1 : longint'(dim_now);
      while (sent < id_budget) begin
         if ($urandom_range(0, 4) == 0) begin
            send_id($urandom, $urandom_range(0, 3) == 0);
            sent++;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
            case ($urandom_range(0, 5))
               0: cur = 64'hFFFF_FFFF - $urandom_range(0, 3 * eff);
               1: cur = $urandom_range(0, 50);
               default: cur = longint'($urandom);
            endcase
            for (k = 0; k < len; k++) begin
               if (k > 0) begin
                  pick = $urandom_range(0, 9);
                  if (pick < 6) begin
                     cur += 1;
                  end else if (pick < 8) begin
                     cur += $urandom_range(2, 4);
                  end else if (pick == 8) begin
                     cur += eff * $urandom_range(1, 2);
                  end
               end
               if (cur > 64'hFFFF_FFFF) begin
                  cur = 64'hFFFF_FFFF;
               end
               fin = (k == len - 1) && ($urandom_range(0, 9) != 0);
               send_id(cur[ID_BITS-1:0], fin);
               sent++;
            end
         end
         if ($urandom_range(0, 24) == 0) begin
            hold_for_columns();
         end
      end
   endtask

   initial begin
      logic [DIM_BITS-1:0] dims[7];
      int p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_id(32'h0000_0000, 1'b1);
      send_id(32'hFFFF_FFFF, 1'b1);
      send_id(32'd5, 1'b0);
      send_id(32'd5, 1'b0);
      send_id(32'd6, 1'b0);
      send_id(32'd9, 1'b1);
      drain_block();

      csr_write(DIM_LENGTH_ADDR, 32'h0000_0000);
      csr_read(DIM_LENGTH_ADDR);
      send_id(32'd10, 1'b0);
      send_id(32'd11, 1'b0);
      send_id(32'd12, 1'b1);
      send_id(32'd100, 1'b0);
      send_id(32'd50, 1'b1);
      drain_block();

      csr_write(UNMAPPED_ADDR, 32'h0000_1234);
      csr_write(DIM_LENGTH_ADDR, 32'hFFFF_FFFF);
      csr_read(DIM_LENGTH_ADDR);
      send_id(32'd0, 1'b0);
      send_id(32'd1, 1'b0);
      send_id(32'd2, 1'b0);
      send_id(32'd65534, 1'b0);
      send_id(32'd65535, 1'b0);
      send_id(32'd65536, 1'b0);
      send_id(32'hFFFF_FFFE, 1'b0);
      send_id(32'hFFFF_FFFF, 1'b1);
      drain_block();

      dims[0] = 16'd1;
      dims[1] = 16'd0;
      dims[2] = 16'hFFFF;
      dims[3] = DIM_BITS'($urandom_range(2, 16));
      dims[4] = DIM_BITS'($urandom_range(17, 4095));
      dims[5] = DIM_BITS'($urandom_range(1, 65535));
      dims[6] = 16'd3;
      for (p = 0; p < 7; p++) begin
         csr_write(DIM_LENGTH_ADDR, {DIM_BITS'($urandom), dims[p]});
         csr_read(DIM_LENGTH_ADDR);
         run_phase(PHASE_IDS);
         drain_block();
      end

      $display("Sent %0d ids over %0d divisor settings;", ids_seen, divisor_settings);
      $display("%0d column records checked, %0d closing a set", records_seen, sets_closed);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
